// ----- hw/rtl/rbm_pkg.sv -----
`timescale 1ns / 1ps

package rbm_pkg;

  // CPU write decode: address bits 15..13 and bit 0
  localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;

  localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR      = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_LATCH   = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ENABLE  = 16'hE001;

  // PPU addresses at or above this are palette accesses and are not watched
  localparam logic [15:0] PPU_PALETTE_BASE = 16'h3F00;
  localparam int unsigned PPU_A12_BIT      = 12;

  localparam int unsigned NUM_BANK_REGS = 8;
  localparam int unsigned BANK_IDX_W    = 3;

  typedef enum logic {
    OP_CPU_WRITE = 1'b0,
    OP_PPU_WATCH = 1'b1
  } op_t;

  // APB register index (byte address / 4)
  typedef enum logic {
    REG_PRG_BANK_COUNT = 1'b0,
    REG_UNUSED         = 1'b1
  } reg_idx_t;

  localparam logic [7:0] PRG_BANK_COUNT_RESET = 8'd2;

endpackage

// ----- hw/rtl/rom_bank_mapper_scanline_irq_unit.sv -----
`timescale 1ns / 1ps

// Cartridge bank mapper with scanline interrupt counter.
//
// Input channel (in_valid / in_stall) carries one item per cycle while in_stall is low: either a CPU
// write to the mapper registers (in_op = 0) or an observation of the PPU
// address bus (in_op = 1). Each accepted item produces exactly one result on
// the output channel (out_valid / out_stall): the bank map, mirroring and IRQ
// line as they stand after the item has been applied.
//
// The item is applied to the mapper state and the result is captured in the output register
// at the accepting edge, so it appears on the output in the next cycle. Throughput is one
// item per cycle; the only storage between the channels is the output register,
// so in_stall is raised only while a result is held and the receiver stalls.
//
// Reset (rst_n low, synchronous) clears all bank registers, modes, IRQ state
// and the A12 filter, sets prg_bank_count to 2 and empties the output register.
// prg_bank_count is written through the APB port at byte address 0; the user must do so
// only while the block is idle, which the block itself does not enforce.
module rom_bank_mapper_scanline_irq_unit
  import rbm_pkg::*;
#(
  parameter int unsigned FILTER_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_prg_bank_map,
  output logic [63:0] out_chr_bank_map,
  output logic        out_mirror_vertical,
  output logic        out_irq_pending,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned FILT_W = $clog2(FILTER_STEPS + 1);

  // mapper state
  logic [7:0]            bank_regs_r [NUM_BANK_REGS];
  logic [7:0]            bank_regs_nxt [NUM_BANK_REGS];
  logic [BANK_IDX_W-1:0] bank_index_r, bank_index_nxt;
  logic                  prg_mode_r, prg_mode_nxt;
  logic                  chr_mode_r, chr_mode_nxt;
  logic                  mirror_r, mirror_nxt;
  logic [7:0]            reload_value_r, reload_value_nxt;
  logic                  reload_req_r, reload_req_nxt;
  logic                  irq_enable_r, irq_enable_nxt;
  logic [7:0]            line_cnt_r, line_cnt_nxt;
  logic [FILT_W-1:0]     filter_r, filter_nxt;
  logic                  last_a12_r, last_a12_nxt;
  logic                  irq_flag_r, irq_flag_nxt;
  logic [7:0]            prg_count_r;

  // output register
  logic        out_valid_r;
  logic [31:0] prg_map_r, prg_map_nxt;
  logic [63:0] chr_map_r, chr_map_nxt;
  logic        mirror_out_r;
  logic        irq_out_r;

  logic       accept;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  logic       a12;
  logic       a12_rise;
  logic [7:0] last0, last1;
  logic [7:0] r0lo, r0hi, r1lo, r1hi;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & (cfg_idx == REG_PRG_BANK_COUNT);
  assign prdata  = (cfg_idx == REG_PRG_BANK_COUNT) ? {24'd0, prg_count_r} : 32'd0;

  assign a12      = in_addr[PPU_A12_BIT];
  assign a12_rise = a12 & ~last_a12_r;

  always_comb begin
    bank_regs_nxt    = bank_regs_r;
    bank_index_nxt   = bank_index_r;
    prg_mode_nxt     = prg_mode_r;
    chr_mode_nxt     = chr_mode_r;
    mirror_nxt       = mirror_r;
    reload_value_nxt = reload_value_r;
    reload_req_nxt   = reload_req_r;
    irq_enable_nxt   = irq_enable_r;
    line_cnt_nxt     = line_cnt_r;
    filter_nxt       = filter_r;
    last_a12_nxt     = last_a12_r;
    irq_flag_nxt     = irq_flag_r;

    if (op_t'(in_op) == OP_CPU_WRITE) begin
      case (in_addr & ADDR_DECODE_MASK)
        ADDR_BANK_SELECT: begin
          bank_index_nxt = in_value[BANK_IDX_W-1:0];
          prg_mode_nxt   = in_value[6];
          chr_mode_nxt   = in_value[7];
        end
        ADDR_BANK_DATA:   bank_regs_nxt[bank_index_r] = in_value;
        ADDR_MIRROR:      mirror_nxt = in_value[0];
        ADDR_IRQ_LATCH:   reload_value_nxt = in_value;
        ADDR_IRQ_RELOAD:  reload_req_nxt = 1'b1;
        ADDR_IRQ_DISABLE: begin
          irq_enable_nxt = 1'b0;
          irq_flag_nxt   = 1'b0;
        end
        ADDR_IRQ_ENABLE:  irq_enable_nxt = 1'b1;
        default: ;
      endcase
    end else if (in_addr < PPU_PALETTE_BASE) begin
      if (a12_rise) begin
        // filter at zero means enough watched fetches since the last rise: count a scanline
        if (filter_r == '0) begin
          if (line_cnt_r == 8'd0 && irq_enable_r) irq_flag_nxt = 1'b1;
          if (line_cnt_r == 8'd0 || reload_req_r) begin
            line_cnt_nxt   = reload_value_r;
            reload_req_nxt = 1'b0;
          end else begin
            line_cnt_nxt = line_cnt_r - 8'd1;
          end
        end
        filter_nxt = FILT_W'(FILTER_STEPS);
      end else if (filter_r != '0) begin
        filter_nxt = filter_r - FILT_W'(1);
      end
      last_a12_nxt = a12;
    end
  end

  // bank map from the post-item state
  assign last0 = {prg_count_r[6:0], 1'b0} - 8'd2;
  assign last1 = {prg_count_r[6:0], 1'b1} - 8'd2;
  assign r0lo  = {bank_regs_nxt[0][7:1], 1'b0};
  assign r0hi  = {bank_regs_nxt[0][7:1], 1'b1};
  assign r1lo  = {bank_regs_nxt[1][7:1], 1'b0};
  assign r1hi  = {bank_regs_nxt[1][7:1], 1'b1};

  always_comb begin
    if (!prg_mode_nxt) begin
      prg_map_nxt = {last1, last0, bank_regs_nxt[7], bank_regs_nxt[6]};
    end else begin
      prg_map_nxt = {last1, bank_regs_nxt[6], bank_regs_nxt[7], last0};
    end
    if (!chr_mode_nxt) begin
      chr_map_nxt = {bank_regs_nxt[5], bank_regs_nxt[4], bank_regs_nxt[3], bank_regs_nxt[2],
                     r1hi, r1lo, r0hi, r0lo};
    end else begin
      chr_map_nxt = {r1hi, r1lo, r0hi, r0lo,
                     bank_regs_nxt[5], bank_regs_nxt[4], bank_regs_nxt[3], bank_regs_nxt[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANK_REGS; i++) bank_regs_r[i] <= 8'd0;
      bank_index_r   <= '0;
      prg_mode_r     <= 1'b0;
      chr_mode_r     <= 1'b0;
      mirror_r       <= 1'b0;
      reload_value_r <= 8'd0;
      reload_req_r   <= 1'b0;
      irq_enable_r   <= 1'b0;
      line_cnt_r     <= 8'd0;
      filter_r       <= '0;
      last_a12_r     <= 1'b0;
      irq_flag_r     <= 1'b0;
    end else if (accept) begin
      bank_regs_r    <= bank_regs_nxt;
      bank_index_r   <= bank_index_nxt;
      prg_mode_r     <= prg_mode_nxt;
      chr_mode_r     <= chr_mode_nxt;
      mirror_r       <= mirror_nxt;
      reload_value_r <= reload_value_nxt;
      reload_req_r   <= reload_req_nxt;
      irq_enable_r   <= irq_enable_nxt;
      line_cnt_r     <= line_cnt_nxt;
      filter_r       <= filter_nxt;
      last_a12_r     <= last_a12_nxt;
      irq_flag_r     <= irq_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r <= PRG_BANK_COUNT_RESET;
    end else if (cfg_wr) begin
      prg_count_r <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prg_map_r    <= prg_map_nxt;
      chr_map_r    <= chr_map_nxt;
      mirror_out_r <= mirror_nxt;
      irq_out_r    <= irq_flag_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_prg_bank_map    = prg_map_r;
  assign out_chr_bank_map    = chr_map_r;
  assign out_mirror_vertical = mirror_out_r;
  assign out_irq_pending     = irq_out_r;

endmodule

// ----- sim/rbm_mapper_checker.sv -----
`timescale 1ns / 1ps

module rbm_mapper_checker
  import rbm_pkg::*;
#(
  parameter int unsigned FILTER_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_prg_bank_map,
  input  logic [63:0] out_chr_bank_map,
  input  logic        out_mirror_vertical,
  input  logic        out_irq_pending,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned error_count,
  output int unsigned results_owed
);

  typedef struct packed {
    logic [31:0] prg_map;
    logic [63:0] chr_map;
    logic        mirror;
    logic        irq;
  } mapper_view_t;

  // mirror of the mapper state
  logic [7:0]  bank_r [NUM_BANK_REGS];
  logic [2:0]  sel_idx;
  logic        prg_swap;
  logic        chr_swap;
  logic        mirror_q;
  logic [7:0]  latch_val;
  logic        reload_req;
  logic        irq_en;
  logic [7:0]  line_cnt;
  int unsigned filter_left;
  logic        a12_prev;
  logic        irq_line;
  logic [7:0]  prg_count;

  mapper_view_t view_q[$];
  mapper_view_t want;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    error_count++;
    $display("ERROR @%0t %s: got %h, wanted %h", $time, what, got, exp_val);
  endtask

  task automatic apply_cpu_write(logic [15:0] a, logic [7:0] v);
    case (a & ADDR_DECODE_MASK)
      ADDR_BANK_SELECT: begin
        sel_idx  = v[2:0];
        prg_swap = v[6];
        chr_swap = v[7];
      end
      ADDR_BANK_DATA:   bank_r[sel_idx] = v;
      ADDR_MIRROR:      mirror_q = v[0];
      ADDR_IRQ_LATCH:   latch_val = v;
      ADDR_IRQ_RELOAD:  reload_req = 1'b1;
      ADDR_IRQ_DISABLE: begin
        irq_en   = 1'b0;
        irq_line = 1'b0;
      end
      ADDR_IRQ_ENABLE:  irq_en = 1'b1;
      default: ;
    endcase
  endtask

  task automatic apply_ppu_watch(logic [15:0] a);
    logic a12;
    if (a >= PPU_PALETTE_BASE)
      return;
    a12 = a[PPU_A12_BIT];
    if (!a12_prev && a12) begin
      // only edges after enough watched fetches since the last rise clock the counter
      if (filter_left == 0) begin
        if (line_cnt == 8'd0 && irq_en)
          irq_line = 1'b1;
        if (line_cnt == 8'd0 || reload_req) begin
          line_cnt   = latch_val;
          reload_req = 1'b0;
        end else begin
          line_cnt = line_cnt - 8'd1;
        end
      end
      filter_left = FILTER_STEPS;
    end else if (filter_left != 0) begin
      filter_left--;
    end
    a12_prev = a12;
  endtask

  function automatic mapper_view_t bank_view();
    mapper_view_t v;
    logic [7:0]   last0, last1;
    logic [31:0]  pair_half, quad_half;
    last0 = (prg_count << 1) - 8'd2;
    last1 = (prg_count << 1) - 8'd1;
    if (!prg_swap)
      v.prg_map = {last1, last0, bank_r[7], bank_r[6]};
    else
      v.prg_map = {last1, bank_r[6], bank_r[7], last0};
    pair_half = {bank_r[1] | 8'h01, bank_r[1] & 8'hFE, bank_r[0] | 8'h01, bank_r[0] & 8'hFE};
    quad_half = {bank_r[5], bank_r[4], bank_r[3], bank_r[2]};
    v.chr_map = chr_swap ? {pair_half, quad_half} : {quad_half, pair_half};
    v.mirror  = mirror_q;
    v.irq     = irq_line;
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANK_REGS; i++)
        bank_r[i] = 8'd0;
      sel_idx     = '0;
      prg_swap    = 1'b0;
      chr_swap    = 1'b0;
      mirror_q    = 1'b0;
      latch_val   = 8'd0;
      reload_req  = 1'b0;
      irq_en      = 1'b0;
      line_cnt    = 8'd0;
      filter_left = 0;
      a12_prev    = 1'b0;
      irq_line    = 1'b0;
      prg_count   = PRG_BANK_COUNT_RESET;
      view_q.delete();
      error_count = 0;
      results_owed <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_PRG_BANK_COUNT, 2'b00})
        prg_count = pwdata[7:0];

      if (out_valid && !out_stall) begin
        if (view_q.size() == 0) begin
          report_mismatch("result with nothing owed", '0, '0);
        end else begin
          want = view_q.pop_front();
          if (out_prg_bank_map !== want.prg_map)
            report_mismatch("prg_bank_map", 64'(out_prg_bank_map), 64'(want.prg_map));
          if (out_chr_bank_map !== want.chr_map)
            report_mismatch("chr_bank_map", out_chr_bank_map, want.chr_map);
          if (out_mirror_vertical !== want.mirror)
            report_mismatch("mirror_vertical", 64'(out_mirror_vertical), 64'(want.mirror));
          if (out_irq_pending !== want.irq)
            report_mismatch("irq_pending", 64'(out_irq_pending), 64'(want.irq));
        end
      end

      if (in_valid && !in_stall) begin
        if (in_op == OP_PPU_WATCH)
          apply_ppu_watch(in_addr);
        else
          apply_cpu_write(in_addr, in_value);
        view_q.push_back(bank_view());
      end

      results_owed <= view_q.size();
    end
  end

endmodule

// ----- sim/rom_bank_mapper_scanline_irq_unit_tb.sv -----
`timescale 1ns / 1ps

module rom_bank_mapper_scanline_irq_unit_tb;
  import rbm_pkg::*;

  localparam int unsigned FILTER_STEPS = 16;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_prg_bank_map;
  logic [63:0] out_chr_bank_map;
  logic        out_mirror_vertical;
  logic        out_irq_pending;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mapper_errors;
  int unsigned results_owed;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned stall_pct;

  rom_bank_mapper_scanline_irq_unit #(
    .FILTER_STEPS(FILTER_STEPS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_addr(in_addr), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_prg_bank_map(out_prg_bank_map), .out_chr_bank_map(out_chr_bank_map),
    .out_mirror_vertical(out_mirror_vertical), .out_irq_pending(out_irq_pending),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rbm_mapper_checker #(
    .FILTER_STEPS(FILTER_STEPS)
  ) mapper_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_addr(in_addr), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_prg_bank_map(out_prg_bank_map), .out_chr_bank_map(out_chr_bank_map),
    .out_mirror_vertical(out_mirror_vertical), .out_irq_pending(out_irq_pending),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .error_count(mapper_errors), .results_owed(results_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rom_bank_mapper_scanline_irq_unit: mismatch");
      $finish;
    end
  end

  task automatic send_item(op_t op, logic [15:0] a, logic [7:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_addr  <= a;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // stop sending and let every owed result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_prg_count(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PRG_BANK_COUNT, 2'b00};
    pwdata  <= {8'($urandom_range(255)), 16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // PPU fetch address below 0x4000, bit 12 chosen by the caller
  function automatic logic [15:0] pattern_addr(logic a12);
    return {2'b00, 1'($urandom), a12, 12'($urandom)};
  endfunction

  task automatic mapper_traffic_item();
    int unsigned pick, low_run;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // one scanline: a run of low fetches then an A12 rise
      low_run = ($urandom_range(99) < 70) ? $urandom_range(15, 20) : $urandom_range(14);
      for (int i = 0; i < low_run; i++) begin
        if ($urandom_range(19) == 0)
          send_item(OP_PPU_WATCH, PPU_PALETTE_BASE | 16'($urandom_range(8'hFF)), 8'($urandom));
        else
          send_item(OP_PPU_WATCH, pattern_addr(1'b0), 8'($urandom));
      end
      send_item(OP_PPU_WATCH, pattern_addr(1'b1), 8'($urandom));
      if ($urandom_range(3) == 0)
        send_item(OP_PPU_WATCH, pattern_addr(1'b1), 8'($urandom));
    end else if (pick < 72) begin
      send_item(OP_CPU_WRITE, {3'($urandom_range(4, 7)), 12'($urandom), 1'($urandom)},
                8'($urandom));
    end else if (pick < 84) begin
      // small reload values make the counter hit zero often
      send_item(OP_CPU_WRITE, ADDR_IRQ_LATCH, 8'($urandom_range(4)));
      if ($urandom_range(1))
        send_item(OP_CPU_WRITE, ADDR_IRQ_RELOAD, 8'($urandom));
      if ($urandom_range(3) == 0)
        send_item(OP_CPU_WRITE, ADDR_IRQ_DISABLE, 8'($urandom));
      send_item(OP_CPU_WRITE, ADDR_IRQ_ENABLE, 8'($urandom));
    end else if (pick < 90) begin
      send_item(OP_CPU_WRITE, ADDR_BANK_SELECT, 8'($urandom));
      send_item(OP_CPU_WRITE, ADDR_BANK_DATA, 8'($urandom));
    end else begin
      send_item(op_t'($urandom_range(1)), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_directed();
    send_item(OP_CPU_WRITE, ADDR_IRQ_ENABLE, 8'h00);
    send_item(OP_PPU_WATCH, PPU_PALETTE_BASE, 8'hFF);
    send_item(OP_PPU_WATCH, 16'hFFFF, 8'h00);
    // first rise after reset: counter at zero and enabled raises the line
    send_item(OP_PPU_WATCH, 16'h1FFF, 8'h55);
    send_item(OP_CPU_WRITE, ADDR_IRQ_DISABLE, 8'h00);
    send_item(OP_CPU_WRITE, ADDR_IRQ_LATCH, 8'hFF);
    send_item(OP_CPU_WRITE, ADDR_IRQ_RELOAD, 8'h00);
    send_item(OP_CPU_WRITE, ADDR_BANK_SELECT, 8'hC7);
    send_item(OP_CPU_WRITE, ADDR_BANK_DATA, 8'hFF);
    send_item(OP_CPU_WRITE, ADDR_BANK_SELECT, 8'h00);
    send_item(OP_CPU_WRITE, ADDR_BANK_DATA, 8'hFF);
    send_item(OP_CPU_WRITE, ADDR_BANK_SELECT, 8'h41);
    send_item(OP_CPU_WRITE, ADDR_BANK_DATA, 8'h00);
    send_item(OP_CPU_WRITE, ADDR_BANK_SELECT, 8'h86);
    send_item(OP_CPU_WRITE, ADDR_BANK_DATA, 8'hAA);
    send_item(OP_CPU_WRITE, ADDR_MIRROR, 8'h01);
    send_item(OP_CPU_WRITE, ADDR_MIRROR | 16'h0001, 8'h00);
    send_item(OP_CPU_WRITE, ADDR_MIRROR, 8'hFE);
    send_item(OP_CPU_WRITE, 16'h0000, 8'hFF);
    // all ones decodes as an IRQ enable
    send_item(OP_CPU_WRITE, 16'hFFFF, 8'h00);
    send_item(OP_PPU_WATCH, 16'h0000, 8'h00);
    send_item(OP_PPU_WATCH, 16'h2FFF, 8'hFF);
    send_item(OP_PPU_WATCH, 16'h3EFF, 8'h00);
  endtask

  initial begin
    logic [7:0] count_plan [5];
    int unsigned idle_plan [5];
    int unsigned stall_plan [5];
    count_plan = '{8'd1, 8'd128, 8'd0, 8'd255, 8'($urandom_range(2, 127))};
    idle_plan  = '{0, 81, 0, 37, 0};
    stall_plan = '{0, 0, 81, 37, 0};

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_op       <= OP_CPU_WRITE;
    in_addr     <= '0;
    in_value    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    stall_pct   <= 0;
    idle_pct    = 0;
    items_sent  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_prg_count(count_plan[p]);
      idle_pct = idle_plan[p];
      stall_pct <= stall_plan[p];
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        mapper_traffic_item();
        if (p == 2 && items_sent >= PHASE_ITEMS / 2 && items_sent < PHASE_ITEMS / 2 + 4)
          drain_results();
      end
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (mapper_errors == 0 && results_owed == 0)
      $display("rom_bank_mapper_scanline_irq_unit: match");
    else
      $display("rom_bank_mapper_scanline_irq_unit: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rbm_pkg.sv
hw/rtl/rom_bank_mapper_scanline_irq_unit.sv
sim/rbm_mapper_checker.sv
sim/rom_bank_mapper_scanline_irq_unit_tb.sv
